/* sv/rmau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmau_pkg
// Shared widths, opcodes and payload types of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package rmau_pkg;
  localparam int MOD_WIDTH = 31;
  localparam int EXP_WIDTH = 63;
  localparam int RAW_WIDTH = 64;
  localparam int OP_WIDTH  = 4;

  typedef logic [MOD_WIDTH-1:0] res_t;

  localparam logic [OP_WIDTH-1:0] OP_REDUCE = 4'd0;
  localparam logic [OP_WIDTH-1:0] OP_ADD    = 4'd1;
  localparam logic [OP_WIDTH-1:0] OP_SUB    = 4'd2;
  localparam logic [OP_WIDTH-1:0] OP_MUL    = 4'd3;
  localparam logic [OP_WIDTH-1:0] OP_DIV    = 4'd4;
  localparam logic [OP_WIDTH-1:0] OP_NEG    = 4'd5;
  localparam logic [OP_WIDTH-1:0] OP_INV    = 4'd6;
  localparam logic [OP_WIDTH-1:0] OP_POW    = 4'd7;
  localparam logic [OP_WIDTH-1:0] OP_EQUAL  = 4'd8;

  typedef struct packed {
    logic [OP_WIDTH-1:0]  operation;
    logic [MOD_WIDTH-1:0] operand_a;
    logic [MOD_WIDTH-1:0] operand_b;
    logic [RAW_WIDTH-1:0] raw_value;
    logic [EXP_WIDTH-1:0] exponent;
  } in_beat_t;

  typedef struct packed {
    logic [MOD_WIDTH-1:0] result;
    logic                 equal;
    logic                 not_invertible;
  } out_beat_t;
endpackage
`default_nettype wire

/* sv/rmau_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmau_in_if
// Valid/ready channel carrying one input beat.
// ----------------------------------------------------------------------------
interface rmau_in_if;
  logic               valid;
  logic               ready;
  rmau_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/rmau_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmau_out_if
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface rmau_out_if;
  logic                valid;
  logic                ready;
  rmau_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/runtime_modulus_arithmetic_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// runtime_modulus_arithmetic_unit
// Modular reduce/add/sub/mul/div/neg/inv/pow/equal with an APB modulus.
// ----------------------------------------------------------------------------
// One beat at a time. A shift-subtract unit reduces the operands and the raw
// value and forms the Euclid quotients, a double-and-add unit does the
// modular multiplies, each one bit per cycle. Add/sub/neg/equal need only the
// operand reductions; mul adds one multiply, pow a square-and-multiply loop,
// inv and div the Euclid loop (div with a final multiply). The result
// sits in an output register; the next beat is taken once it is delivered.
module runtime_modulus_arithmetic_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rmau_in_if.sink                           in_ch,
  rmau_out_if.source                        out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [0:0]                   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic      [31:0]                  cfg_prdata,
  output logic                              cfg_pready
);
  localparam int W = rmau_pkg::MOD_WIDTH;
  localparam int R = rmau_pkg::RAW_WIDTH;
  localparam int E = rmau_pkg::EXP_WIDTH;
  localparam int CW = 7;

  localparam logic [3:0] S_IDLE = 4'd0, S_RA = 4'd1, S_RB = 4'd2, S_DISP = 4'd3,
    S_RAW = 4'd4, S_MUL = 4'd5, S_POWD = 4'd6, S_DIVQ = 4'd7, S_EUM = 4'd8,
    S_EUD = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11, S_RED = 4'd12;
  localparam logic [1:0] M_POWR = 2'd0, M_POWB = 2'd1, M_EUC = 2'd2, M_FIN = 2'd3;

  logic [W-1:0] mod_r;
  logic [3:0]   st_r, st_nxt;
  logic [3:0]   ret_r, ret_nxt;
  logic [1:0]   mk_r, mk_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]   op_r, op_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [R-1:0] raw_r, raw_nxt;
  logic [E-1:0] e_r, e_nxt;
  // shared shift-subtract unit: dividend shifts out of sh_r into rem_r
  logic [R-1:0] sh_r, sh_nxt;
  logic [W:0]   rem_r, rem_nxt;
  // multiplier operands and accumulator
  logic [W-1:0] ma_r, ma_nxt, mb_r, mb_nxt, acc_r, acc_nxt;
  // euclid state
  logic [W-1:0] ea_r, ea_nxt, eb_r, eb_nxt, u_r, u_nxt, v_r, v_nxt;
  logic [W-1:0] pr_r, pr_nxt;
  logic         bad_r, bad_nxt;
  rmau_pkg::out_beat_t ob_r, ob_nxt;
  logic         ov_r, ov_nxt;

  logic [W-1:0] m;
  assign m = (mod_r == '0) ? W'(1) : mod_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(mod_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) begin
      mod_r <= cfg_pwdata[W-1:0];
    end
  end

  assign in_ch.ready = (st_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data = ob_r;

  // one restoring step: shift next dividend bit in, subtract divisor if fits
  logic [W+1:0] tr, dv;
  logic [W:0]   rstep;
  logic         qbit;
  always_comb begin
    dv = {2'b0, (st_r == S_DIVQ) ? eb_r : m};
    tr = {rem_r, sh_r[R-1]};
    qbit = (tr >= dv);
    rstep = qbit ? (W+1)'(tr - dv) : tr[W:0];
  end

  // double-and-add step, intermediates below 2m
  logic [W:0] dbl, dsum;
  logic [W-1:0] dred, astep;
  always_comb begin
    dbl = {acc_r, 1'b0};
    dred = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
    dsum = {1'b0, dred} + {1'b0, ma_r};
    astep = mb_r[W-1] ? ((dsum >= {1'b0, m}) ? W'(dsum - {1'b0, m}) : dsum[W-1:0])
                      : dred;
  end

  logic [W:0] addsum;
  assign addsum = {1'b0, a_r} + {1'b0, b_r};

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; mk_nxt = mk_r; cnt_nxt = cnt_r;
    op_nxt = op_r; a_nxt = a_r; b_nxt = b_r; raw_nxt = raw_r; e_nxt = e_r;
    sh_nxt = sh_r; rem_nxt = rem_r; ma_nxt = ma_r; mb_nxt = mb_r; acc_nxt = acc_r;
    ea_nxt = ea_r; eb_nxt = eb_r; u_nxt = u_r; v_nxt = v_r; pr_nxt = pr_r;
    bad_nxt = bad_r; ob_nxt = ob_r; ov_nxt = ov_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          op_nxt = in_ch.data.operation; a_nxt = in_ch.data.operand_a;
          b_nxt = in_ch.data.operand_b; raw_nxt = in_ch.data.raw_value;
          e_nxt = in_ch.data.exponent; bad_nxt = 1'b0;
          sh_nxt = {in_ch.data.operand_a, {(R-W){1'b0}}};
          rem_nxt = '0; cnt_nxt = CW'(W); ret_nxt = S_RA; st_nxt = S_RED;
        end
      end
      S_RED: begin
        rem_nxt = rstep; sh_nxt = {sh_r[R-2:0], 1'b0};
        if (cnt_r == CW'(1)) st_nxt = ret_r;
        cnt_nxt = cnt_r - CW'(1);
      end
      S_RA: begin
        a_nxt = rem_r[W-1:0];
        sh_nxt = {b_r, {(R-W){1'b0}}}; rem_nxt = '0; cnt_nxt = CW'(W);
        ret_nxt = S_RB; st_nxt = S_RED;
      end
      S_RB: begin
        b_nxt = rem_r[W-1:0]; st_nxt = S_DISP;
      end
      S_DISP: begin
        ob_nxt = '0; st_nxt = S_OUT;
        unique case (op_r)
          rmau_pkg::OP_REDUCE: begin
            sh_nxt = raw_r[R-1] ? (R'(0) - raw_r) : raw_r;
            rem_nxt = '0; cnt_nxt = CW'(R); ret_nxt = S_RAW; st_nxt = S_RED;
          end
          rmau_pkg::OP_ADD:
            ob_nxt.result = (addsum >= {1'b0, m}) ? W'(addsum - {1'b0, m})
                                                  : addsum[W-1:0];
          rmau_pkg::OP_SUB:
            ob_nxt.result = (a_r >= b_r) ? W'(a_r - b_r) : W'(a_r + (m - b_r));
          rmau_pkg::OP_NEG: ob_nxt.result = (a_r == '0) ? '0 : W'(m - a_r);
          rmau_pkg::OP_EQUAL: ob_nxt.equal = (a_r == b_r);
          rmau_pkg::OP_MUL: begin
            ma_nxt = a_r; mb_nxt = b_r; acc_nxt = '0; cnt_nxt = CW'(W);
            mk_nxt = M_FIN; st_nxt = S_MUL;
          end
          rmau_pkg::OP_POW: begin
            pr_nxt = (m == W'(1)) ? '0 : W'(1); st_nxt = S_POWD;
          end
          rmau_pkg::OP_INV, rmau_pkg::OP_DIV: begin
            ea_nxt = (op_r == rmau_pkg::OP_INV) ? a_r : b_r; eb_nxt = m;
            u_nxt = (m == W'(1)) ? '0 : W'(1); v_nxt = '0; st_nxt = S_EUD;
          end
          default: ;
        endcase
      end
      S_RAW: begin
        ob_nxt.result = (!raw_r[R-1] || rem_r == '0) ? rem_r[W-1:0]
                                                       : W'(m - rem_r[W-1:0]);
        st_nxt = S_OUT;
      end
      S_MUL: begin
        acc_nxt = astep; mb_nxt = {mb_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          unique case (mk_r)
            M_POWR: begin
              pr_nxt = astep; ma_nxt = a_r; mb_nxt = a_r; acc_nxt = '0;
              cnt_nxt = CW'(W); mk_nxt = M_POWB;
            end
            M_POWB: begin
              a_nxt = astep; e_nxt = e_r >> 1; st_nxt = S_POWD;
            end
            M_EUC: begin
              v_nxt = (u_r >= astep) ? W'(u_r - astep) : W'(u_r + (m - astep));
              u_nxt = v_r; st_nxt = S_EUD;
            end
            M_FIN: begin
              ob_nxt.result = astep; st_nxt = S_OUT;
            end
            default: ;
          endcase
        end
      end
      S_POWD: begin
        if (e_r == '0) begin
          ob_nxt.result = pr_r; st_nxt = S_OUT;
        end else begin
          acc_nxt = '0; cnt_nxt = CW'(W); st_nxt = S_MUL;
          if (e_r[0]) begin
            ma_nxt = pr_r; mb_nxt = a_r; mk_nxt = M_POWR;
          end else begin
            ma_nxt = a_r; mb_nxt = a_r; mk_nxt = M_POWB;
          end
        end
      end
      S_EUD: begin
        if (eb_r == '0) begin
          bad_nxt = (ea_r != W'(1));
          if (op_r == rmau_pkg::OP_INV) begin
            ob_nxt.result = u_r; ob_nxt.not_invertible = bad_nxt; st_nxt = S_OUT;
          end else begin
            ma_nxt = a_r; mb_nxt = u_r; acc_nxt = '0; cnt_nxt = CW'(W);
            mk_nxt = M_FIN; st_nxt = S_MUL;
          end
        end else begin
          sh_nxt = {ea_r, {(R-W){1'b0}}}; rem_nxt = '0; cnt_nxt = CW'(W);
          st_nxt = S_DIVQ; pr_nxt = '0;
        end
      end
      S_DIVQ: begin
        // quotient bits collect in pr_r; quotient never exceeds m
        rem_nxt = rstep; sh_nxt = {sh_r[R-2:0], 1'b0};
        pr_nxt = {pr_r[W-2:0], qbit}; cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          st_nxt = S_EUM;
        end
      end
      S_EUM: begin
        // multiply reduces t, so t == m folds to zero
        ea_nxt = eb_r; eb_nxt = rem_r[W-1:0];
        ma_nxt = v_r; mb_nxt = pr_r; acc_nxt = '0; cnt_nxt = CW'(W);
        mk_nxt = M_EUC; st_nxt = S_MUL;
      end
      S_FIN: st_nxt = S_OUT;
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
          if (op_r == rmau_pkg::OP_DIV) ob_nxt.not_invertible = bad_r;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
    ret_r <= ret_nxt; mk_r <= mk_nxt; cnt_r <= cnt_nxt; op_r <= op_nxt;
    a_r <= a_nxt; b_r <= b_nxt; raw_r <= raw_nxt; e_r <= e_nxt;
    sh_r <= sh_nxt; rem_r <= rem_nxt; ma_r <= ma_nxt; mb_r <= mb_nxt;
    acc_r <= acc_nxt; ea_r <= ea_nxt; eb_r <= eb_nxt; u_r <= u_nxt;
    v_r <= v_nxt; pr_r <= pr_nxt; bad_r <= bad_nxt; ob_r <= ob_nxt;
  end
endmodule
`default_nettype wire

/* sv/rmau_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmau_checker
// Port-level checks of the modular arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmau_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_equal,
  input wire logic out_not_invertible,
  input wire logic cfg_pready
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_equal && out_not_invertible)) else $error("both flags");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("beat dropped");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind runtime_modulus_arithmetic_unit rmau_checker u_rmau_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_equal(out_ch.data.equal),
  .out_not_invertible(out_ch.data.not_invertible), .cfg_pready(cfg_pready)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-time modulus arithmetic unit: beats are
// queued per modulus setting, predicted on acceptance and compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rmau_in_if  in_ch ();
  rmau_out_if out_ch ();

  runtime_modulus_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  localparam logic [0:0] REG_MODULUS = 1'b0;
  localparam longint unsigned MOD_MASK = (64'd1 << rmau_pkg::MOD_WIDTH) - 1;
  localparam longint unsigned EXP_MASK = (64'd1 << rmau_pkg::EXP_WIDTH) - 1;

  rmau_pkg::in_beat_t   pending_beats[$];
  rmau_pkg::out_beat_t  expected_results[$];
  longint unsigned  cur_modulus;
  int               idle_pct;
  int               errors;
  bit               in_taken;

  function automatic longint unsigned add_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    longint unsigned s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic longint unsigned sub_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    longint unsigned r;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = add_mod(r, r, m);
      if (b[i]) r = add_mod(r, a, m);
    end
    return r;
  endfunction

  function automatic longint unsigned inv_mod(longint unsigned x, longint unsigned m,
                                              output bit bad);
    longint unsigned ga, gb, cu, cv, q, na, nu;
    ga = x; gb = m; cu = 1 % m; cv = 0;
    while (gb > 0) begin
      q  = ga / gb;
      na = ga - q * gb;
      nu = sub_mod(cu, mul_mod(q % m, cv, m), m);
      ga = gb; gb = na; cu = cv; cv = nu;
    end
    bad = (ga != 1);
    return cu;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned x, longint unsigned n,
                                              longint unsigned m);
    longint unsigned r, base;
    r = 1 % m; base = x;
    while (n > 0) begin
      if (n[0]) r = mul_mod(r, base, m);
      base = mul_mod(base, base, m);
      n = n >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned reduce_signed(longint unsigned raw, longint unsigned m);
    longint unsigned r;
    if (!raw[63]) return raw % m;
    r = (64'd0 - raw) % m;
    return (r == 0) ? 0 : m - r;
  endfunction

  function automatic rmau_pkg::out_beat_t modular_result(rmau_pkg::in_beat_t b);
    longint unsigned m, a, c, res;
    bit bad, eq;
    rmau_pkg::out_beat_t o;
    m = (cur_modulus == 0) ? 1 : cur_modulus;
    a = 64'(b.operand_a) % m;
    c = 64'(b.operand_b) % m;
    res = 0; bad = 0; eq = 0;
    case (b.operation)
      rmau_pkg::OP_REDUCE: res = reduce_signed(b.raw_value, m);
      rmau_pkg::OP_ADD:    res = add_mod(a, c, m);
      rmau_pkg::OP_SUB:    res = sub_mod(a, c, m);
      rmau_pkg::OP_MUL:    res = mul_mod(a, c, m);
      rmau_pkg::OP_DIV:    res = mul_mod(a, inv_mod(c, m, bad), m);
      rmau_pkg::OP_NEG:    res = (a == 0) ? 0 : m - a;
      rmau_pkg::OP_INV:    res = inv_mod(a, m, bad);
      rmau_pkg::OP_POW:    res = pow_mod(a, 64'(b.exponent) & EXP_MASK, m);
      rmau_pkg::OP_EQUAL:  eq = (a == c);
      default:   ;
    endcase
    o.result = res[rmau_pkg::MOD_WIDTH-1:0];
    o.equal = eq;
    o.not_invertible = bad;
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(modular_result(in_ch.data));
      in_taken = 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        rmau_pkg::out_beat_t e;
        e = expected_results.pop_front();
        if (out_ch.data.result !== e.result) begin
          $error("result: expected %0d actual %0d", e.result, out_ch.data.result);
          errors++;
        end
        if (out_ch.data.equal !== e.equal) begin
          $error("equal: expected %0d actual %0d", e.equal, out_ch.data.equal);
          errors++;
        end
        if (out_ch.data.not_invertible !== e.not_invertible) begin
          $error("not_invertible: expected %0d actual %0d", e.not_invertible,
                 out_ch.data.not_invertible);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!(in_ch.valid && !in_taken)) begin
      if (rst_n && pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_ch.data  <= pending_beats.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_taken = 0;
    out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  task automatic write_modulus(logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = REG_MODULUS; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    cur_modulus = 64'(value) & MOD_MASK;
  endtask

  task automatic queue_beat(logic [3:0] op, logic [30:0] a, logic [30:0] b,
                            logic [63:0] raw, logic [62:0] e);
    rmau_pkg::in_beat_t t;
    t.operation = op; t.operand_a = a; t.operand_b = b;
    t.raw_value = raw; t.exponent = e;
    pending_beats.push_back(t);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() || expected_results.size() || in_ch.valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_operand();
    longint unsigned m;
    m = (cur_modulus == 0) ? 1 : cur_modulus;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 31'(m - 1);
      3: return 31'($urandom);
      default: return 31'({$urandom, $urandom} % m);
    endcase
  endfunction

  task automatic queue_random(int count);
    logic [3:0]  op;
    logic [62:0] e;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
      e = ($urandom_range(0, 3) == 0) ? 63'({$urandom, $urandom})
                                      : 63'($urandom_range(0, 300));
      queue_beat(op, pick_operand(), pick_operand(), {$urandom, $urandom}, e);
    end
  endtask

  task automatic queue_directed();
    queue_beat(rmau_pkg::OP_REDUCE, 0, 0, 64'h8000_0000_0000_0000, 0);
    queue_beat(rmau_pkg::OP_REDUCE, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    queue_beat(rmau_pkg::OP_REDUCE, 0, 0, '1, 0);
    queue_beat(rmau_pkg::OP_REDUCE, 0, 0, 0, 0);
    queue_beat(rmau_pkg::OP_ADD, '1, '1, 0, 0);
    queue_beat(rmau_pkg::OP_SUB, 0, '1, 0, 0);
    queue_beat(rmau_pkg::OP_MUL, '1, '1, 0, 0);
    queue_beat(rmau_pkg::OP_DIV, '1, 0, 0, 0);
    queue_beat(rmau_pkg::OP_DIV, 5, 2, 0, 0);
    queue_beat(rmau_pkg::OP_NEG, 0, 0, 0, 0);
    queue_beat(rmau_pkg::OP_NEG, '1, 0, 0, 0);
    queue_beat(rmau_pkg::OP_INV, 0, 0, 0, 0);
    queue_beat(rmau_pkg::OP_INV, 2, 0, 0, 0);
    queue_beat(rmau_pkg::OP_INV, '1, 0, 0, 0);
    queue_beat(rmau_pkg::OP_POW, 3, 0, 0, 0);
    queue_beat(rmau_pkg::OP_POW, '1, 0, 0, '1);
    queue_beat(rmau_pkg::OP_EQUAL, 7, 7, 0, 0);
    queue_beat(rmau_pkg::OP_EQUAL, '1, 0, 0, 0);
    queue_beat(4'd15, '1, '1, '1, '1);
  endtask

  initial begin
    logic [31:0] moduli[6];
    moduli = '{32'd0, 32'h7FFF_FFFF, 32'd1, 32'd1_000_000, 32'hFFFF_FFFF, 32'd2};
    errors = 0; idle_pct = 21; in_taken = 0;
    cur_modulus = 1;
    rst_n = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 0; in_ch.data = '0; out_ch.ready = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    queue_directed();
    queue_random(10);
    wait_idle();
    for (int p = 0; p < 6; p++) begin
      write_modulus(moduli[p]);
      idle_pct = (p == 3) ? 0 : 21;
      queue_directed();
      queue_random(p == 1 ? 40 : 20);
      wait_idle();
    end
    write_modulus({1'b0, 31'($urandom_range(3, 65535))});
    queue_random(20);
    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
